/* hw/rtl/eadf_pkg.sv */
// Package for the encoder acceleration and direction filter.
// Holds shared widths, constants, register indexes, the sequencer state type and the
// request struct used between the sequencer and the direction filter. No dependencies.
`default_nettype none

package eadf_pkg;

  // Field widths
  localparam int unsigned RAW_W    = 16;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned LIMIT_W  = 16;
  localparam int unsigned COEF_W   = 8;
  localparam int unsigned STEP_W   = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned S_DATA_W = 48;
  localparam int unsigned M_DATA_W = 8;

  // Shared multiplier operands: the line equation value needs 26 bits,
  // the interval or the raw count 17 bits, and the product 43 bits.
  localparam int unsigned MUL_A_W = 26;
  localparam int unsigned MUL_B_W = 17;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

  localparam int unsigned HISTORY_DEPTH_DEF = 4;
  localparam logic [TIME_W-1:0] IDLE_GAP_MS = 32'd50;

  // Magnitude at which a count is consumed, and the clamp bounds of a step
  localparam logic signed [RAW_W-1:0]  CONSUME_HI = 16'sd4;
  localparam logic signed [RAW_W-1:0]  CONSUME_LO = -16'sd4;
  localparam logic signed [PROD_W-1:0] STEP_HI = 43'sd4;
  localparam logic signed [PROD_W-1:0] STEP_LO = -43'sd4;

  // Reset values of the configuration registers
  localparam logic                      ACCEL_EN_RST = 1'b0;
  localparam logic [LIMIT_W-1:0]        FAST_LIMIT_RST = 16'd100;
  localparam logic signed [COEF_W-1:0]  SLOPE_RST = 8'sd1;
  localparam logic signed [COEF_W-1:0]  OFFSET_RST = 8'sd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACCEL_EN   = 2'd0,
    CFG_FAST_LIMIT = 2'd1,
    CFG_SLOPE      = 2'd2,
    CFG_OFFSET     = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK,
    ST_MUL1,
    ST_OFS,
    ST_MUL2,
    ST_FIN
  } seq_state_e;

  typedef struct packed {
    logic              upd;
    logic              pos;
    logic [TIME_W-1:0] now;
  } dir_req_t;

endpackage

`default_nettype wire

/* hw/rtl/eadf_mul.sv */
// Shared signed multiplier with a registered product.
// Depends on eadf_pkg for operand and product widths.
`default_nettype none

module eadf_mul (
  input  wire logic                                      clk_i,
  input  wire logic                                      en_i,
  input  wire logic signed [eadf_pkg::MUL_A_W-1:0]       a_i,
  input  wire logic signed [eadf_pkg::MUL_B_W-1:0]       b_i,
  output logic signed [eadf_pkg::PROD_W-1:0]             p_o
);

  logic signed [eadf_pkg::PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

/* hw/rtl/eadf_dirfilt.sv */
// Direction filter: direction history and time of the last turn.
// Depends on eadf_pkg for the request struct and the idle gap constant.
`default_nettype none

module eadf_dirfilt #(
  parameter int unsigned HistDepth = eadf_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire eadf_pkg::dir_req_t  req_i,
  output logic                     send_o
);

  logic [eadf_pkg::TIME_W-1:0] last_turn_q, last_turn_d;
  logic [HistDepth-1:0]        hist_q, hist_d;
  logic [eadf_pkg::TIME_W-1:0] since_turn;
  logic                        gap;
  logic                        match;

  assign since_turn = req_i.now - last_turn_q;
  assign gap        = since_turn >= eadf_pkg::IDLE_GAP_MS;
  assign match      = hist_q == {HistDepth{req_i.pos}};
  assign send_o     = gap | match;

  // On a match every bit already equals the new sign, so shifting it in
  // leaves the history as it is; only an idle gap rewrites it.
  always_comb begin
    last_turn_d = last_turn_q;
    hist_d      = hist_q;
    if (req_i.upd) begin
      last_turn_d = req_i.now;
      if (gap) begin
        hist_d = {HistDepth{req_i.pos}};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_turn_q <= '0;
      hist_q      <= '0;
    end else begin
      last_turn_q <= last_turn_d;
      hist_q      <= hist_d;
    end
  end

  a_turn_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.upd |=> last_turn_q == $past(req_i.now))
    else $error("last turn time not taken from the update");

  a_gap_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.upd && gap) |=> hist_q == {HistDepth{$past(req_i.pos)}})
    else $error("history not refilled after an idle gap");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.upd && !gap) |=> $stable(hist_q))
    else $error("history changed without an idle gap");

endmodule

`default_nettype wire

/* hw/rtl/encoder_accel_direction_filter.sv */
// Top level of the encoder acceleration and direction filter: stream ports,
// configuration registers, sequencer and output register.
// Depends on eadf_pkg, eadf_mul and eadf_dirfilt.
//
//   Channel   Signals                               Fields (lowest bit up)
//   s_axis    s_axis_tvalid/tready/tdata[47:0]      raw_count[15:0], now_ms[47:16]
//   m_axis    m_axis_tvalid/tready/tdata[7:0]       consumed[0], send[1], step[5:2], 0
//   cfg       cfg_we_i, cfg_idx_i[1:0], cfg_data_i  0 accel_enable, 1 fast_interval_limit,
//                                                   2 accel_slope, 3 accel_offset
//
// An accepted item goes to the check state, then straight to the final state,
// which loads the output register, when no acceleration applies. When it
// does, the line equation and the scaled count each take one pass through the
// single shared multiplier, with the offset added in a state between them.
// The sequencer then returns to idle, in which the next item is taken.
// Ready is high only while the sequencer is idle; a finished result waits in
// the output register, so the next item is taken while it is still pending.
// A full output register that is not drained holds the sequencer in its
// final state. Reset clears the configuration to its defaults and the time
// and direction history to zero.
`default_nettype none

module encoder_accel_direction_filter #(
  parameter int unsigned HistoryDepth = eadf_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // raw_count [15:0], now_ms [47:16]
  input  wire logic [eadf_pkg::S_DATA_W-1:0]      s_axis_tdata,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // consumed [0], send [1], step [5:2], zero [7:6]
  output logic [eadf_pkg::M_DATA_W-1:0]           m_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  input  wire logic                               cfg_we_i,
  input  wire logic [eadf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [eadf_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned RawW  = eadf_pkg::RAW_W;
  localparam int unsigned TimeW = eadf_pkg::TIME_W;
  localparam int unsigned ProdW = eadf_pkg::PROD_W;
  localparam int unsigned AW    = eadf_pkg::MUL_A_W;
  localparam int unsigned BW    = eadf_pkg::MUL_B_W;
  localparam int unsigned StepW = eadf_pkg::STEP_W;

  // Configuration registers
  logic                                      accel_en_q;
  logic [eadf_pkg::LIMIT_W-1:0]              limit_q;
  logic signed [eadf_pkg::COEF_W-1:0]        slope_q;
  logic signed [eadf_pkg::COEF_W-1:0]        offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_en_q <= eadf_pkg::ACCEL_EN_RST;
      limit_q    <= eadf_pkg::FAST_LIMIT_RST;
      slope_q    <= eadf_pkg::SLOPE_RST;
      offset_q   <= eadf_pkg::OFFSET_RST;
    end else if (cfg_we_i) begin
      unique case (eadf_pkg::cfg_idx_e'(cfg_idx_i))
        eadf_pkg::CFG_ACCEL_EN:   accel_en_q <= cfg_data_i[0];
        eadf_pkg::CFG_FAST_LIMIT: limit_q    <= cfg_data_i;
        eadf_pkg::CFG_SLOPE:      slope_q    <= cfg_data_i[eadf_pkg::COEF_W-1:0];
        eadf_pkg::CFG_OFFSET:     offset_q   <= cfg_data_i[eadf_pkg::COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and working registers
  eadf_pkg::seq_state_e state_q, state_d;

  logic                       s_fire;
  logic signed [RawW-1:0]     raw_q;
  logic [TimeW-1:0]           now_q;
  logic [TimeW-1:0]           last_accel_q, last_accel_d;
  logic                       consumed_q, consumed_d;
  logic                       use_mul_q, use_mul_d;
  logic [eadf_pkg::LIMIT_W-1:0] rev_q, rev_d;
  logic signed [AW-1:0]       mult_q, mult_d;

  logic                       is_consumed;
  logic [TimeW-1:0]           interval;
  logic                       fast;

  logic                       mul_en;
  logic signed [AW-1:0]       mul_a;
  logic signed [BW-1:0]       mul_b;
  logic signed [ProdW-1:0]    prod;

  logic signed [ProdW-1:0]    v_sel;
  logic signed [ProdW-1:0]    v_bias;
  logic signed [ProdW-1:0]    v_quo;
  logic signed [StepW-1:0]    step_val;
  logic                       pos;
  logic                       send;
  eadf_pkg::dir_req_t         dir_req;

  logic                       out_load;
  logic                       out_valid_q, out_valid_d;
  logic                       out_consumed_q, out_send_q;
  logic signed [StepW-1:0]    out_step_q;

  assign s_axis_tready = state_q == eadf_pkg::ST_IDLE;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // Consumption and interval check on the captured item
  assign is_consumed = (raw_q >= eadf_pkg::CONSUME_HI) || (raw_q <= eadf_pkg::CONSUME_LO);
  assign interval    = now_q - last_accel_q;
  assign fast        = interval < {{(TimeW - eadf_pkg::LIMIT_W){1'b0}}, limit_q};

  // Operand selection for the shared multiplier:
  // first pass slope * (limit - interval), second pass line value * count.
  always_comb begin
    mul_en = 1'b0;
    mul_a  = AW'(slope_q);
    mul_b  = {1'b0, rev_q};
    unique case (state_q)
      eadf_pkg::ST_MUL1: begin
        mul_en = 1'b1;
      end
      eadf_pkg::ST_MUL2: begin
        mul_en = 1'b1;
        mul_a  = mult_q;
        mul_b  = BW'(raw_q);
      end
      default: ;
    endcase
  end

  eadf_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // Divide by four truncating toward zero, then clamp
  always_comb begin
    v_sel  = use_mul_q ? prod : ProdW'(raw_q);
    v_bias = v_sel + (v_sel[ProdW-1] ? ProdW'(3) : ProdW'(0));
    v_quo  = v_bias >>> 2;
    if (v_quo > eadf_pkg::STEP_HI) begin
      step_val = StepW'(eadf_pkg::STEP_HI);
    end else if (v_quo < eadf_pkg::STEP_LO) begin
      step_val = StepW'(eadf_pkg::STEP_LO);
    end else begin
      step_val = v_quo[StepW-1:0];
    end
  end

  // A zero step counts as a negative direction
  assign pos = !step_val[StepW-1] && (step_val != '0);

  assign out_load = (state_q == eadf_pkg::ST_FIN) && (!out_valid_q || m_axis_tready);

  always_comb begin
    dir_req.upd = out_load && consumed_q;
    dir_req.pos = pos;
    dir_req.now = now_q;
  end

  eadf_dirfilt #(
    .HistDepth (HistoryDepth)
  ) u_dirfilt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dir_req),
    .send_o (send)
  );

  always_comb begin
    state_d      = state_q;
    last_accel_d = last_accel_q;
    consumed_d   = consumed_q;
    use_mul_d    = use_mul_q;
    rev_d        = rev_q;
    mult_d       = mult_q;
    unique case (state_q)
      eadf_pkg::ST_IDLE: begin
        if (s_fire) begin
          state_d = eadf_pkg::ST_CHK;
        end
      end
      eadf_pkg::ST_CHK: begin
        consumed_d = is_consumed;
        use_mul_d  = 1'b0;
        rev_d      = limit_q - interval[eadf_pkg::LIMIT_W-1:0];
        if (is_consumed && accel_en_q) begin
          last_accel_d = now_q;
          use_mul_d    = fast;
        end
        state_d = (is_consumed && accel_en_q && fast) ? eadf_pkg::ST_MUL1
                                                      : eadf_pkg::ST_FIN;
      end
      eadf_pkg::ST_MUL1: begin
        state_d = eadf_pkg::ST_OFS;
      end
      eadf_pkg::ST_OFS: begin
        // add the offset to slope * (limit - interval)
        mult_d  = prod[AW-1:0] + AW'(offset_q);
        state_d = eadf_pkg::ST_MUL2;
      end
      eadf_pkg::ST_MUL2: begin
        state_d = eadf_pkg::ST_FIN;
      end
      eadf_pkg::ST_FIN: begin
        if (out_load) begin
          state_d = eadf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = eadf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= eadf_pkg::ST_IDLE;
      last_accel_q <= '0;
      consumed_q   <= 1'b0;
      use_mul_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      last_accel_q <= last_accel_d;
      consumed_q   <= consumed_d;
      use_mul_q    <= use_mul_d;
    end
  end

  // Payload registers: capture the item, hold the line value
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      raw_q <= s_axis_tdata[RawW-1:0];
      now_q <= s_axis_tdata[RawW +: TimeW];
    end
    rev_q  <= rev_d;
    mult_q <= mult_d;
  end

  // Output register: drop the item once taken, reload from the final state
  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // An unconsumed count yields all-zero fields
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_consumed_q <= consumed_q;
      out_send_q     <= consumed_q && send;
      out_step_q     <= consumed_q ? step_val : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(eadf_pkg::M_DATA_W - StepW - 2){1'b0}},
                          out_step_q, out_send_q, out_consumed_q};

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_step_q <= 4'sd4) && (out_step_q >= -4'sd4))
    else $error("step outside the clamp range");

  a_unconsumed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !out_consumed_q) |-> (!out_send_q && (out_step_q == '0)))
    else $error("unconsumed count produced a step");

  a_accept_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> state_q == eadf_pkg::ST_CHK)
    else $error("accepted item not checked in the next cycle");

  a_accel_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == eadf_pkg::ST_CHK && !(is_consumed && accel_en_q)) |=> $stable(last_accel_q))
    else $error("acceleration time changed without a consumed accelerated turn");

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// Self-checking testbench for the encoder acceleration and direction filter.
// Depends on eadf_pkg and the encoder_accel_direction_filter RTL, with eadf_mul and eadf_dirfilt beneath it.
// A queue-fed driver, a checking monitor and a stall watchdog run against a step predictor.
`default_nettype none

module tb_top;

  localparam int unsigned TIME_W     = eadf_pkg::TIME_W;
  localparam int unsigned RAW_W      = eadf_pkg::RAW_W;
  localparam int unsigned STEP_W     = eadf_pkg::STEP_W;
  localparam int unsigned S_DATA_W   = eadf_pkg::S_DATA_W;
  localparam int unsigned M_DATA_W   = eadf_pkg::M_DATA_W;
  localparam int unsigned CFG_IDX_W  = eadf_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W = eadf_pkg::CFG_DATA_W;
  localparam int unsigned LIMIT_W    = eadf_pkg::LIMIT_W;
  localparam int unsigned COEF_W     = eadf_pkg::COEF_W;

  localparam int unsigned HIST_W   = eadf_pkg::HISTORY_DEPTH_DEF;
  localparam int unsigned WD_LIMIT = 5000;
  localparam int unsigned HOLD_LEN = 400;
  localparam int unsigned SEG_LEN  = 185;

  // One poll as it travels on s_axis: raw_count in the low bits, now_ms above
  typedef struct packed {
    logic [TIME_W-1:0]       now;
    logic signed [RAW_W-1:0] raw;
  } poll_t;

  typedef struct packed {
    logic                     consumed;
    logic                     send;
    logic signed [STEP_W-1:0] step;
  } step_res_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic [S_DATA_W-1:0]   s_axis_tdata  = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [M_DATA_W-1:0]   m_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  // Polls waiting to be offered, and steps predicted for accepted polls
  poll_t     poll_q[$];
  step_res_t step_q[$];

  int unsigned err_cnt      = 0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned hold_seq     = 0;
  int unsigned hold_seen    = 0;
  int unsigned hold_cnt     = 0;
  int unsigned stall_cnt    = 0;
  logic [TIME_W-1:0] t_now  = '0;

  // Predictor copy of the configuration and the filter state, at reset values
  logic                     p_accel_en   = eadf_pkg::ACCEL_EN_RST;
  logic [LIMIT_W-1:0]       p_fast_limit = eadf_pkg::FAST_LIMIT_RST;
  logic signed [COEF_W-1:0] p_slope      = eadf_pkg::SLOPE_RST;
  logic signed [COEF_W-1:0] p_offset     = eadf_pkg::OFFSET_RST;
  logic [TIME_W-1:0]        p_last_accel = '0;
  logic [TIME_W-1:0]        p_last_turn  = '0;
  logic [HIST_W-1:0]        p_hist       = '0;

  encoder_accel_direction_filter u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Work out the step for one poll and advance the predictor state
  function automatic step_res_t predict_step(logic signed [RAW_W-1:0] raw,
                                             logic [TIME_W-1:0] now);
    step_res_t         res;
    longint            val;
    longint            mult;
    logic [TIME_W-1:0] ival;
    logic [TIME_W-1:0] gap;
    logic [HIST_W-1:0] same;
    logic              pos;
    res = '0;
    val = longint'(raw);
    // Small counts stay in the encoder: nothing consumed, state untouched
    if (val < 4 && val > -4) begin
      return res;
    end
    if (p_accel_en) begin
      ival = now - p_last_accel;
      p_last_accel = now;
      if (ival < {16'd0, p_fast_limit}) begin
        mult = longint'(p_slope) * longint'({16'd0, p_fast_limit} - ival)
               + longint'(p_offset);
        val  = val * mult;
      end
    end
    val = val / 4;
    if (val > 4) begin
      val = 4;
    end
    if (val < -4) begin
      val = -4;
    end
    // A zero step counts as negative
    pos  = (val > 0);
    same = pos ? {HIST_W{1'b1}} : {HIST_W{1'b0}};
    gap  = now - p_last_turn;
    if (gap >= eadf_pkg::IDLE_GAP_MS) begin
      res.send = 1'b1;
      p_hist   = same;
    end else if (p_hist == same) begin
      res.send = 1'b1;
      p_hist   = {p_hist[HIST_W-2:0], pos};
    end
    p_last_turn  = now;
    res.consumed = 1'b1;
    res.step     = val[STEP_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, longint exp_v, longint got_v);
    $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what, exp_v, got_v);
    err_cnt++;
  endtask

  // Driver: offer the oldest pending poll, hold it until taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        step_q.push_back(predict_step(poll_q[0].raw, poll_q[0].now));
        void'(poll_q.pop_front());
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        s_axis_tvalid <= 1'b1;
      end else if (poll_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= poll_q[0];
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: check each step against the oldest prediction, stall at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (step_q.size() == 0) begin
          report_mismatch("unexpected step item (pending count)", 0, 1);
        end else begin
          if (m_axis_tdata[0] !== step_q[0].consumed) begin
            report_mismatch("consumed", step_q[0].consumed, m_axis_tdata[0]);
          end
          if (m_axis_tdata[1] !== step_q[0].send) begin
            report_mismatch("send", step_q[0].send, m_axis_tdata[1]);
          end
          if (m_axis_tdata[5:2] !== step_q[0].step) begin
            report_mismatch("step", step_q[0].step, $signed(m_axis_tdata[5:2]));
          end
          void'(step_q.pop_front());
        end
      end
      // A fresh hold request starts a long stretch with ready low
      if (hold_cnt != 0) begin
        hold_cnt      <= hold_cnt - 1;
        m_axis_tready <= 1'b0;
      end else if (hold_seen != hold_seq) begin
        hold_seen     <= hold_seq;
        hold_cnt      <= HOLD_LEN;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Watchdog: give up when nothing moves on either side for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= WD_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  task automatic push_poll(logic signed [RAW_W-1:0] raw, logic [TIME_W-1:0] now);
    poll_t p;
    p.raw = raw;
    p.now = now;
    poll_q.push_back(p);
  endtask

  task automatic write_reg(eadf_pkg::cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      eadf_pkg::CFG_ACCEL_EN:   p_accel_en   = val[0];
      eadf_pkg::CFG_FAST_LIMIT: p_fast_limit = val;
      eadf_pkg::CFG_SLOPE:      p_slope      = val[COEF_W-1:0];
      eadf_pkg::CFG_OFFSET:     p_offset     = val[COEF_W-1:0];
      default: ;
    endcase
  endtask

  // Load all four registers back to back; only call while the block is idle
  task automatic cfg_load(logic en, logic [LIMIT_W-1:0] lim,
                          logic signed [COEF_W-1:0] slope, logic signed [COEF_W-1:0] ofs);
    write_reg(eadf_pkg::CFG_ACCEL_EN, {15'd0, en});
    write_reg(eadf_pkg::CFG_FAST_LIMIT, lim);
    write_reg(eadf_pkg::CFG_SLOPE, {{8{slope[COEF_W-1]}}, slope});
    write_reg(eadf_pkg::CFG_OFFSET, {{8{ofs[COEF_W-1]}}, ofs});
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Wait until every poll is taken and every step is back, then let the pipe settle
  task automatic wait_drained();
    do begin
      @(negedge clk_i);
    end while (poll_q.size() != 0 || step_q.size() != 0 || s_axis_tvalid);
    repeat (8) @(negedge clk_i);
  endtask

  // Mostly runs of one direction at turning speed, with some noise mixed in
  task automatic queue_random(int unsigned n);
    int unsigned       k;
    int unsigned       run_left;
    int unsigned       sel;
    int unsigned       mag;
    bit                neg;
    logic [TIME_W-1:0] gap;
    logic signed [RAW_W-1:0] raw;
    run_left = 0;
    neg      = 1'b0;
    for (k = 0; k < n; k++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(2, 10);
        neg      = 1'($urandom_range(1));
      end
      run_left--;
      sel = $urandom_range(99);
      if (sel < 70) begin
        gap = $urandom_range(40);
      end else if (sel < 85) begin
        gap = $urandom_range(41, 160);
      end else if (sel < 95) begin
        gap = $urandom_range(50, 5000);
      end else begin
        gap = $urandom;
      end
      t_now = t_now + gap;
      sel = $urandom_range(99);
      if (sel < 75) begin
        mag = $urandom_range(4, 12);
      end else if (sel < 85) begin
        mag = $urandom_range(13, 600);
      end else begin
        mag = $urandom_range(3);
      end
      raw = neg ? -RAW_W'(mag) : RAW_W'(mag);
      // Break the run now and then, or throw in a count from anywhere
      if (sel >= 93) begin
        raw = RAW_W'($urandom);
      end else if ($urandom_range(99) < 5) begin
        raw = -raw;
      end
      push_poll(raw, t_now);
    end
  endtask

  initial begin
    int unsigned seg;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: extremes of the count, thresholds, idle gap, mismatches, time wrap
    src_idle_pct = 20;
    snk_idle_pct = 84;
    push_poll(16'sh7fff, 32'd100);
    push_poll(-16'sh8000, 32'd110);
    push_poll(16'sd3, 32'd120);
    push_poll(-16'sd3, 32'd121);
    push_poll(16'sd0, 32'd122);
    push_poll(16'sd4, 32'd130);
    push_poll(-16'sd4, 32'd135);
    push_poll(16'sd7, 32'd140);
    push_poll(-16'sd5, 32'd300);
    push_poll(16'sd5, 32'd305);
    push_poll(-16'sd7, 32'd310);
    push_poll(16'sd16, 32'hffff_fff0);
    push_poll(16'sd17, 32'h0000_0010);
    push_poll(-16'sd32767, 32'h0000_0020);
    wait_drained();

    // Directed with acceleration: zero and large multipliers, on counts of both signs
    cfg_load(1'b1, 16'd100, 8'sd1, -8'sd10);
    push_poll(16'sd8, 32'd1000);
    push_poll(16'sd8, 32'd1090);
    push_poll(16'sd8, 32'd1100);
    push_poll(-16'sd8, 32'd1105);
    push_poll(16'sd8, 32'd1110);
    push_poll(16'sd8, 32'd1205);
    push_poll(-16'sh8000, 32'd1206);
    wait_drained();
    t_now = 32'd2000;

    for (seg = 0; seg < 6; seg++) begin
      case (seg)
        0: cfg_load(1'b0, eadf_pkg::FAST_LIMIT_RST, eadf_pkg::SLOPE_RST,
                    eadf_pkg::OFFSET_RST);
        1: cfg_load(1'b1, 16'd100, 8'sd1, 8'sd1);
        2: cfg_load(1'b1, 16'hffff, 8'sd127, 8'sd127);
        3: cfg_load(1'b1, 16'd0, -8'sd128, -8'sd128);
        4: cfg_load(1'b1, LIMIT_W'($urandom_range(200)), COEF_W'($urandom),
                    COEF_W'($urandom));
        default: cfg_load(1'($urandom_range(1)), LIMIT_W'($urandom), COEF_W'($urandom),
                          COEF_W'($urandom));
      endcase
      // A busy receiver first, then a slow sender, then full speed
      if (seg < 2) begin
        src_idle_pct = 20;
        snk_idle_pct = 84;
      end else if (seg < 4) begin
        src_idle_pct = 84;
        snk_idle_pct = 20;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      if (seg == 1) begin
        // Hold the receiver off while polls keep coming, so the block backs up
        queue_random(SEG_LEN);
        repeat (30) @(negedge clk_i);
        hold_seq++;
      end else if (seg == 3) begin
        // Pause the sender until every step is back, then carry on
        queue_random(SEG_LEN / 2);
        wait_drained();
        queue_random(SEG_LEN - SEG_LEN / 2);
      end else if (seg == 4) begin
        queue_random(SEG_LEN);
        repeat (20) @(negedge clk_i);
        hold_seq++;
      end else begin
        queue_random(SEG_LEN);
      end
      wait_drained();
    end

    repeat (20) @(negedge clk_i);
    if (step_q.size() != 0) begin
      report_mismatch("steps left over (count)", 0, step_q.size());
    end
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
hw/rtl/eadf_pkg.sv
hw/rtl/eadf_mul.sv
hw/rtl/eadf_dirfilt.sv
hw/rtl/encoder_accel_direction_filter.sv
sim/tb_top.sv
